FILE: sv/stok_pkg.sv
// Shared types and constants for the script tokenizer stream core.
// No dependencies; imported by script_tokenizer_stream_core.
package stok_pkg;

    // Width of the integer accumulator; literals wrap modulo 2**VALUE_BITS (8..64)
    localparam int VALUE_BITS = 32;

    localparam int KIND_W  = 5;
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd0;
    localparam logic [KIND_W-1:0] KIND_STRING  = 5'd1;
    localparam logic [KIND_W-1:0] KIND_INT     = 5'd2;
    localparam logic [KIND_W-1:0] KIND_LPAREN  = 5'd3;
    localparam logic [KIND_W-1:0] KIND_RPAREN  = 5'd4;
    localparam logic [KIND_W-1:0] KIND_LBRACE  = 5'd5;
    localparam logic [KIND_W-1:0] KIND_RBRACE  = 5'd6;
    localparam logic [KIND_W-1:0] KIND_COMMA   = 5'd7;
    localparam logic [KIND_W-1:0] KIND_PLUS    = 5'd8;
    localparam logic [KIND_W-1:0] KIND_MINUS   = 5'd9;
    localparam logic [KIND_W-1:0] KIND_STAR    = 5'd10;
    localparam logic [KIND_W-1:0] KIND_SLASH   = 5'd11;
    localparam logic [KIND_W-1:0] KIND_PERCENT = 5'd12;
    localparam logic [KIND_W-1:0] KIND_LT      = 5'd13;
    localparam logic [KIND_W-1:0] KIND_GT      = 5'd15;
    localparam logic [KIND_W-1:0] KIND_ASSIGN  = 5'd17;
    localparam logic [KIND_W-1:0] KIND_NOT     = 5'd19;
    localparam logic [KIND_W-1:0] KIND_LBRACK  = 5'd21;
    localparam logic [KIND_W-1:0] KIND_RBRACK  = 5'd22;
    localparam logic [KIND_W-1:0] KIND_AND     = 5'd23;
    localparam logic [KIND_W-1:0] KIND_OR      = 5'd25;
    localparam logic [KIND_W-1:0] KIND_NONE    = 5'd0;

    // Characters with a meaning of their own
    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_NL      = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_QUOTE   = 8'h22;
    localparam logic [CHAR_W-1:0] CH_HASH    = 8'h23;
    localparam logic [CHAR_W-1:0] CH_AMP     = 8'h26;
    localparam logic [CHAR_W-1:0] CH_DASH    = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_EQ      = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_BAR     = 8'h7C;
    localparam logic [CHAR_W-1:0] CASE_BIT   = 8'h20;

    // One result word
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic [CHAR_W-1:0]  ch;
        logic               char_valid;
        logic               text_end;
        logic               last;
    } res_t;

    // Single-character operator kinds; KIND_NONE for anything else
    function automatic logic [KIND_W-1:0] op_kind(input logic [CHAR_W-1:0] b);
        logic [KIND_W-1:0] k;
        case (b)
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h2C:   k = KIND_COMMA;
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h2F:   k = KIND_SLASH;
            8'h25:   k = KIND_PERCENT;
            8'h3C:   k = KIND_LT;
            8'h3E:   k = KIND_GT;
            8'h3D:   k = KIND_ASSIGN;
            8'h21:   k = KIND_NOT;
            8'h5B:   k = KIND_LBRACK;
            8'h5D:   k = KIND_RBRACK;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

FILE: sv/script_tokenizer_stream_core.sv
// Streaming script tokenizer: one text byte in, up to two token words out.
// Depends on stok_pkg (kinds, characters, result word type).
// Latency: a token word is offered on m_ the cycle after the byte that completes it,
// once the words queued ahead of it have gone.
// Throughput: one byte per cycle while the four-word result queue has room for two;
// the input stalls when words pile up, from two-word bytes or from m_tready low.
// Reset: aresetn (synchronous, active low) returns the lexer to idle and empties
// the queue; a zero byte clears the lexer to idle after flushing any pending token.
module script_tokenizer_stream_core
    import stok_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] int_value, [39:32] text_char
    output logic [6:0]  m_tuser,   // [4:0] token_kind, [5] char_valid, [6] text_end
    output logic        m_tlast    // run_last
);

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'd0,
        MODE_IDENT   = 4'd1,
        MODE_STRING  = 4'd2,
        MODE_COMMENT = 4'd3,
        MODE_MINUS   = 4'd4,
        MODE_ZERO    = 4'd5,
        MODE_DEC     = 4'd6,
        MODE_HEX     = 4'd7,
        MODE_OP      = 4'd8
    } mode_t;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    mode_t                  mode_reg, mode_next;
    logic [CHAR_W-1:0]      held_char_reg, held_char_next;
    logic                   held_valid_reg, held_valid_next;
    logic [VALUE_BITS-1:0]  accum_reg, accum_next;
    logic                   neg_reg, neg_next;
    logic [KIND_W-1:0]      pend_reg, pend_next;

    res_t                   queue_reg [QDEPTH];
    logic [QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]      count_reg, count_next;

    logic [CHAR_W-1:0]      b;
    logic                   accept, pop;
    logic                   do_top;
    logic                   e0_valid, e1_valid;
    res_t                   e0, e1;
    logic [KIND_W-1:0]      op_k;
    logic                   is_letter, is_var, is_digit, is_hex;
    logic [CHAR_W-1:0]      b_fold;
    logic [4:0]             hex_nib;
    logic [VALUE_BITS-1:0]  num_signed;
    logic [63:0]            num_wide;
    logic [VALUE_W-1:0]     num_value;
    logic [QCNT_W-1:0]      push_cnt;

    assign b      = s_tdata;
    assign accept = s_tvalid && s_tready;
    assign pop    = m_tvalid && m_tready;

    // Classification, quirks included: case folding by OR with 0x20
    assign b_fold    = b | CASE_BIT;
    assign is_letter = (b_fold >= CH_LOWER_A) && (b_fold <= CH_LOWER_Z);
    assign is_var    = is_letter || ((b_fold >= CH_ZERO) && (b_fold <= CH_NINE));
    assign is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_hex    = ((b_fold >= CH_ZERO) && (b_fold <= CH_NINE)) ||
                       ((b_fold >= CH_LOWER_A) && (b_fold <= CH_LOWER_F));
    assign hex_nib   = {1'b0, b[3:0]} + ((b >= CH_UPPER_A) ? 5'd9 : 5'd0);
    assign op_k      = op_kind(b);

    // Finished literal: apply sign, then sign-extend/truncate to the 32-bit field
    assign num_signed = neg_reg ? (VALUE_BITS'(0) - accum_reg) : accum_reg;
    assign num_wide   = 64'(signed'(num_signed));
    assign num_value  = num_wide[VALUE_W-1:0];

    always_comb begin
        mode_next       = mode_reg;
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        accum_next      = accum_reg;
        neg_next        = neg_reg;
        pend_next       = pend_reg;
        do_top          = 1'b0;
        e0_valid        = 1'b0;
        e1_valid        = 1'b0;
        e0              = '0;
        e1              = '0;

        case (mode_reg)
            MODE_IDENT: begin
                e0_valid = 1'b1;
                e0.kind  = KIND_IDENT;
                e0.ch    = held_char_reg;
                e0.char_valid = 1'b1;
                if (is_var) begin
                    held_char_next = b;
                end else begin
                    e0.text_end     = 1'b1;
                    held_valid_next = 1'b0;
                    do_top          = 1'b1;
                end
            end
            MODE_STRING: begin
                if (b == CH_QUOTE || b == CH_NUL) begin
                    e0_valid      = 1'b1;
                    e0.kind       = KIND_STRING;
                    e0.ch         = held_valid_reg ? held_char_reg : '0;
                    e0.char_valid = held_valid_reg;
                    e0.text_end   = 1'b1;
                    held_valid_next = 1'b0;
                    mode_next       = MODE_IDLE;
                    if (b == CH_NUL) begin
                        held_char_next = '0;
                        accum_next     = '0;
                        neg_next       = 1'b0;
                        pend_next      = KIND_NONE;
                    end
                end else begin
                    // hold this character back, release the previous one
                    e0_valid      = held_valid_reg;
                    e0.kind       = KIND_STRING;
                    e0.ch         = held_char_reg;
                    e0.char_valid = 1'b1;
                    held_char_next  = b;
                    held_valid_next = 1'b1;
                end
            end
            MODE_COMMENT: begin
                if (b == CH_NL) begin
                    mode_next = MODE_IDLE;
                end else if (b == CH_NUL) begin
                    mode_next       = MODE_IDLE;
                    held_char_next  = '0;
                    held_valid_next = 1'b0;
                    accum_next      = '0;
                    neg_next        = 1'b0;
                    pend_next       = KIND_NONE;
                end
            end
            MODE_MINUS: begin
                if (is_digit) begin
                    neg_next   = 1'b1;
                    accum_next = VALUE_BITS'(b[3:0]);
                    mode_next  = (b == CH_ZERO) ? MODE_ZERO : MODE_DEC;
                end else begin
                    e0_valid = 1'b1;
                    e0.kind  = KIND_MINUS;
                    do_top   = 1'b1;
                end
            end
            MODE_ZERO, MODE_DEC: begin
                if (mode_reg == MODE_ZERO && (b == CH_LOWER_X || b == CH_UPPER_X)) begin
                    mode_next = MODE_HEX;
                end else if (is_digit) begin
                    mode_next  = MODE_DEC;
                    accum_next = (accum_reg << 3) + (accum_reg << 1) + VALUE_BITS'(b[3:0]);
                end else begin
                    e0_valid   = 1'b1;
                    e0.kind    = KIND_INT;
                    e0.value   = num_value;
                    accum_next = '0;
                    neg_next   = 1'b0;
                    do_top     = 1'b1;
                end
            end
            MODE_HEX: begin
                if (is_hex) begin
                    accum_next = (accum_reg << 4) + VALUE_BITS'(hex_nib);
                end else begin
                    e0_valid   = 1'b1;
                    e0.kind    = KIND_INT;
                    e0.value   = num_value;
                    accum_next = '0;
                    neg_next   = 1'b0;
                    do_top     = 1'b1;
                end
            end
            MODE_OP: begin
                e0_valid  = 1'b1;
                pend_next = KIND_NONE;
                if ((b == CH_EQ && (pend_reg == KIND_LT || pend_reg == KIND_GT ||
                                    pend_reg == KIND_ASSIGN || pend_reg == KIND_NOT)) ||
                    (b == CH_AMP && pend_reg == KIND_AND) ||
                    (b == CH_BAR && pend_reg == KIND_OR)) begin
                    e0.kind   = pend_reg + KIND_W'(1);
                    mode_next = MODE_IDLE;
                end else begin
                    e0.kind = pend_reg;
                    do_top  = 1'b1;
                end
            end
            default: begin
                do_top = 1'b1;
            end
        endcase

        // Start of a new token, from idle or from the byte that ended the last token
        if (do_top) begin
            mode_next = MODE_IDLE;
            if (b == CH_NUL) begin
                held_char_next  = '0;
                held_valid_next = 1'b0;
                accum_next      = '0;
                neg_next        = 1'b0;
                pend_next       = KIND_NONE;
            end else if (is_letter) begin
                mode_next       = MODE_IDENT;
                held_char_next  = b;
                held_valid_next = 1'b1;
            end else if (is_digit) begin
                neg_next   = 1'b0;
                accum_next = VALUE_BITS'(b[3:0]);
                mode_next  = (b == CH_ZERO) ? MODE_ZERO : MODE_DEC;
            end else if (b == CH_DASH) begin
                mode_next = MODE_MINUS;
            end else if (b == CH_QUOTE) begin
                mode_next       = MODE_STRING;
                held_valid_next = 1'b0;
            end else if (b == CH_HASH) begin
                mode_next = MODE_COMMENT;
            end else if (b == CH_AMP) begin
                mode_next = MODE_OP;
                pend_next = KIND_AND;
            end else if (b == CH_BAR) begin
                mode_next = MODE_OP;
                pend_next = KIND_OR;
            end else if (op_k == KIND_LT || op_k == KIND_GT ||
                         op_k == KIND_ASSIGN || op_k == KIND_NOT) begin
                mode_next = MODE_OP;
                pend_next = op_k;
            end else if (op_k != KIND_NONE) begin
                if (e0_valid) begin
                    e1_valid = 1'b1;
                    e1.kind  = op_k;
                end else begin
                    e0_valid = 1'b1;
                    e0.kind  = op_k;
                end
            end
        end

        // Mark the last word of this byte
        if (e1_valid) begin
            e1.last = 1'b1;
        end else begin
            e0.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            held_char_reg  <= '0;
            held_valid_reg <= 1'b0;
            accum_reg      <= '0;
            neg_reg        <= 1'b0;
            pend_reg       <= KIND_NONE;
        end else if (accept) begin
            mode_reg       <= mode_next;
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
            accum_reg      <= accum_next;
            neg_reg        <= neg_next;
            pend_reg       <= pend_next;
        end
    end

    // Result queue: up to two words pushed, one popped per cycle while m_tready is high
    assign push_cnt   = accept ? (QCNT_W'(e0_valid) + QCNT_W'(e1_valid)) : '0;
    assign count_next = count_reg + push_cnt - QCNT_W'(pop);
    assign s_tready   = (count_reg <= QCNT_W'(QDEPTH - 2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_cnt[QPTR_W-1:0];
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && e0_valid) begin
            queue_reg[wr_ptr_reg] <= e0;
        end
        if (accept && e1_valid) begin
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= e1;
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {queue_reg[rd_ptr_reg].ch, queue_reg[rd_ptr_reg].value};
    assign m_tuser  = {queue_reg[rd_ptr_reg].text_end, queue_reg[rd_ptr_reg].char_valid,
                       queue_reg[rd_ptr_reg].kind};
    assign m_tlast  = queue_reg[rd_ptr_reg].last;

    // Queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    // An end-of-text byte leaves the lexer fully cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && b == CH_NUL) |=>
            (mode_reg == MODE_IDLE && !held_valid_reg && accum_reg == '0 &&
             !neg_reg && pend_reg == KIND_NONE))
        else $error("state not cleared after end of text");

    // A held character exists only inside an identifier or a string
    assert property (@(posedge aclk) disable iff (!aresetn)
        held_valid_reg |-> (mode_reg == MODE_IDENT || mode_reg == MODE_STRING))
        else $error("held character outside ident or string");

    // Identifier mode always carries its held character
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_IDENT) |-> held_valid_reg)
        else $error("identifier without held character");

    // A pending operator exists only in operator mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg != KIND_NONE) |-> (mode_reg == MODE_OP))
        else $error("pending operator outside operator mode");

endmodule
